/* hw/rtl/sslw_pkg.sv */
// sslw_pkg: shared types and constants for the servo slew limiter with steering
// no dependencies; used by sslw_slew and the top level

package sslw_pkg;

   // default structure
   localparam int NUM_CHANNELS_DEF  = 3;
   localparam int STEER_CHANNEL_DEF = 0;
   localparam int NUM_RATE_REGS     = 3;

   // field widths
   localparam int POS_W    = 16;
   localparam int RATE_W   = 8;
   localparam int GAIN_W   = 8;
   localparam int CODE_W   = 8;
   localparam int MAG_W    = 7;
   localparam int AMP_W    = MAG_W + GAIN_W;
   localparam int KIND_W   = 2;
   localparam int CHAN_W   = 2;
   localparam int BUMP_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // position limits and reset values
   localparam logic [POS_W-1:0] POS_MAX   = 16'd10000;
   localparam logic [POS_W-1:0] POS_MIN   = 16'd2000;
   localparam logic [POS_W-1:0] POS_RESET = 16'd6000;

   localparam logic [POS_W-1:0]  CENTER_RESET = 16'd6000;
   localparam logic [POS_W-1:0]  LEFT_RESET   = 16'd2000;
   localparam logic [POS_W-1:0]  RIGHT_RESET  = 16'd10000;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 8'd1;
   localparam logic [POS_W-1:0]  NEUTRAL_RESET = 16'd6000;

   // bumper debounce
   localparam logic [BUMP_W-1:0] BUMP_MAX       = 4'd10;
   localparam logic [BUMP_W-1:0] BUMP_THRESHOLD = 4'd5;

   // offset code layout: sign in the top bit
   localparam int SIGN_BIT = CODE_W - 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 2'd0,
      KIND_OFFSET  = 2'd1,
      KIND_NEUTRAL = 2'd2,
      KIND_CENTER  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RATE_CH0    = 3'd0,
      REG_RATE_CH1    = 3'd1,
      REG_RATE_CH2    = 3'd2,
      REG_STEER_CTR   = 3'd3,
      REG_STEER_LEFT  = 3'd4,
      REG_STEER_RIGHT = 3'd5,
      REG_STEER_GAIN  = 3'd6,
      REG_NEUTRAL     = 3'd7
   } csr_reg_type;

endpackage

/* hw/rtl/sslw_slew.sv */
// sslw_slew: one tick of slew limiting for a single channel
// depends on sslw_pkg for widths and position limits

module sslw_slew import sslw_pkg::*; (
   input  logic [POS_W-1:0]  cur,
   input  logic [POS_W-1:0]  tgt,
   input  logic [RATE_W-1:0] rate,
   output logic [POS_W-1:0]  nxt
);

   logic [POS_W-1:0] rate_ext;
   logic [POS_W-1:0] cur_up;
   logic [POS_W-1:0] cur_dn;

   assign rate_ext = {{(POS_W-RATE_W){1'b0}}, rate};

   always_comb begin
      cur_up = (tgt > cur) ? cur + rate_ext : cur;
      // second compare sees the raised value
      cur_dn = (tgt < cur_up) ? cur_up - rate_ext : cur_up;
      if (rate == '0) begin
         nxt = tgt;
      end else if (cur_dn > POS_MAX) begin
         nxt = POS_MAX;
      end else if (cur_dn < POS_MIN) begin
         nxt = POS_MIN;
      end else begin
         nxt = cur_dn;
      end
   end

endmodule

/* hw/rtl/servo_slew_limiter_with_steering.sv */
// servo_slew_limiter_with_steering: top level, command decode, steering and debounce
// depends on sslw_pkg and sslw_slew
//
//  channel | direction | ports               | transfer
//  --------+-----------+---------------------+-----------------------------
//  req     | in        | req_valid/req_ready | command or tick item
//  rsp     | out       | rsp_valid/rsp_ready | positions and bumper flag
//  csr     | in        | csr_write_en        | register write, no wait
//
//  an item passes through the input register and then the result register, and while rsp
//  is not stalled the block takes one item per cycle
//  all state updates for an item are made in the single cycle it leaves the input register
//  reset is synchronous and active high; positions and targets return to their rest value
//  a stalled rsp holds the result register, the input register holds behind it, and
//  req_ready drops only when both are full

module servo_slew_limiter_with_steering import sslw_pkg::*; #(
   parameter int NUM_CHANNELS  = NUM_CHANNELS_DEF,
   parameter int STEER_CHANNEL = STEER_CHANNEL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic                  req_bumper_open,
   input  logic [CODE_W-1:0]     req_offset_code,
   input  logic [CHAN_W-1:0]     req_channel,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [POS_W-1:0]      rsp_pos_ch0,
   output logic [POS_W-1:0]      rsp_pos_ch1,
   output logic [POS_W-1:0]      rsp_pos_ch2,
   output logic                  rsp_bumper_pressed,
   // register writes
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [RATE_W-1:0] rate_ff [NUM_RATE_REGS];
   logic [POS_W-1:0]  center_ff;
   logic [POS_W-1:0]  left_ff;
   logic [POS_W-1:0]  right_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [POS_W-1:0]  neutral_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_RATE_REGS; k++) begin
            rate_ff[k] <= '0;
         end
         center_ff  <= CENTER_RESET;
         left_ff    <= LEFT_RESET;
         right_ff   <= RIGHT_RESET;
         gain_ff    <= GAIN_RESET;
         neutral_ff <= NEUTRAL_RESET;
      end else if (csr_write_en) begin
         unique case (csr_reg_type'(csr_index))
            // rate registers for channels that do not exist are dropped
            REG_RATE_CH0: begin
               if (NUM_CHANNELS > 0) rate_ff[0] <= csr_wdata[RATE_W-1:0];
            end
            REG_RATE_CH1: begin
               if (NUM_CHANNELS > 1) rate_ff[1] <= csr_wdata[RATE_W-1:0];
            end
            REG_RATE_CH2: begin
               if (NUM_CHANNELS > 2) rate_ff[2] <= csr_wdata[RATE_W-1:0];
            end
            REG_STEER_CTR:   center_ff  <= csr_wdata[POS_W-1:0];
            REG_STEER_LEFT:  left_ff    <= csr_wdata[POS_W-1:0];
            REG_STEER_RIGHT: right_ff   <= csr_wdata[POS_W-1:0];
            REG_STEER_GAIN:  gain_ff    <= csr_wdata[GAIN_W-1:0];
            REG_NEUTRAL:     neutral_ff <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // input register and handshake
   // ---------------------------------------------------------------
   logic             s1_valid_ff;
   kind_type         s1_kind_ff;
   logic             s1_open_ff;
   logic [CODE_W-1:0] s1_code_ff;
   logic [CHAN_W-1:0] s1_chan_ff;
   logic             rsp_valid_ff;
   logic             s1_fire;   // item leaves the input register this cycle
   logic             req_fire;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_fire) begin
         s1_kind_ff <= kind_type'(req_kind);
         s1_open_ff <= req_bumper_open;
         s1_code_ff <= req_offset_code;
         s1_chan_ff <= req_channel;
      end
   end

   logic is_tick;
   logic is_offset;
   logic is_neutral;
   logic is_center;

   always_comb begin
      is_tick    = 1'b0;
      is_offset  = 1'b0;
      is_neutral = 1'b0;
      is_center  = 1'b0;
      unique case (s1_kind_ff)
         KIND_TICK:    is_tick    = 1'b1;
         KIND_OFFSET:  is_offset  = 1'b1;
         KIND_NEUTRAL: is_neutral = 1'b1;
         KIND_CENTER:  is_center  = 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // steering target from a signed offset
   // ---------------------------------------------------------------
   logic [AMP_W-1:0] amp;
   logic [POS_W:0]   steer_up;       // one spare bit so the sum cannot wrap
   logic [POS_W:0]   left_plus_amp;
   logic             over_right;
   logic             under_left;
   logic [POS_W-1:0] steer_tgt;

   assign amp = {{(AMP_W-MAG_W){1'b0}}, s1_code_ff[MAG_W-1:0]}
              * {{(AMP_W-GAIN_W){1'b0}}, gain_ff};
   assign steer_up      = {1'b0, center_ff} + {{(POS_W+1-AMP_W){1'b0}}, amp};
   assign left_plus_amp = {1'b0, left_ff} + {{(POS_W+1-AMP_W){1'b0}}, amp};
   assign over_right    = steer_up > {1'b0, right_ff};
   // center - amp < left, kept unsigned by moving amp across
   assign under_left    = {1'b0, center_ff} < left_plus_amp;

   always_comb begin
      // right limit wins over left limit, both checked whatever the sign
      priority if (over_right) begin
         steer_tgt = right_ff;
      end else if (under_left) begin
         steer_tgt = left_ff;
      end else if (s1_code_ff[SIGN_BIT]) begin
         steer_tgt = steer_up[POS_W-1:0];
      end else begin
         steer_tgt = center_ff - {{(POS_W-AMP_W){1'b0}}, amp};
      end
   end

   // ---------------------------------------------------------------
   // bumper debounce
   // ---------------------------------------------------------------
   logic [BUMP_W-1:0] bump_ff;
   logic [BUMP_W-1:0] bump_in;

   always_comb begin
      bump_in = bump_ff;
      if (s1_fire && is_tick) begin
         if (s1_open_ff) begin
            if (bump_ff != '0) bump_in = bump_ff - 1'b1;
         end else begin
            if (bump_ff < BUMP_MAX) bump_in = bump_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // channel state
   // ---------------------------------------------------------------
   logic [POS_W-1:0]  target_ff  [NUM_CHANNELS];
   logic [POS_W-1:0]  target_in  [NUM_CHANNELS];
   logic [POS_W-1:0]  current_ff [NUM_CHANNELS];
   logic [POS_W-1:0]  current_in [NUM_CHANNELS];
   logic [POS_W-1:0]  slew_nxt   [NUM_CHANNELS];
   logic [RATE_W-1:0] chan_rate  [NUM_CHANNELS];

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      // channels beyond the rate registers follow their target directly
      if (i < NUM_RATE_REGS) begin : g_rate
         assign chan_rate[i] = rate_ff[i];
      end else begin : g_norate
         assign chan_rate[i] = '0;
      end

      sslw_slew u_slew (
         .cur  (current_ff[i]),
         .tgt  (target_ff[i]),
         .rate (chan_rate[i]),
         .nxt  (slew_nxt[i])
      );

      always_comb begin
         target_in[i]  = target_ff[i];
         current_in[i] = current_ff[i];
         if (s1_fire) begin
            if (is_tick) current_in[i] = slew_nxt[i];
            if (is_neutral && (int'(s1_chan_ff) == i)) target_in[i] = neutral_ff;
            if (i == STEER_CHANNEL) begin
               if (is_offset) target_in[i] = steer_tgt;
               if (is_center) target_in[i] = center_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            target_ff[k]  <= POS_RESET;
            current_ff[k] <= POS_RESET;
         end
         bump_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            target_ff[k]  <= target_in[k];
            current_ff[k] <= current_in[k];
         end
         bump_ff <= bump_in;
      end
   end

   // ---------------------------------------------------------------
   // result register, shows the state left by the item
   // ---------------------------------------------------------------
   logic [POS_W-1:0] res_pos [3];
   logic [POS_W-1:0] rsp_pos_ff [3];
   logic             rsp_bump_ff;

   for (genvar j = 0; j < 3; j++) begin : g_res
      if (j < NUM_CHANNELS) begin : g_live
         assign res_pos[j] = current_in[j];
      end else begin : g_absent
         assign res_pos[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_fire) begin
         for (int k = 0; k < 3; k++) begin
            rsp_pos_ff[k] <= res_pos[k];
         end
         rsp_bump_ff <= (bump_in > BUMP_THRESHOLD);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_ch0        = rsp_pos_ff[0];
   assign rsp_pos_ch1        = rsp_pos_ff[1];
   assign rsp_pos_ch2        = rsp_pos_ff[2];
   assign rsp_bumper_pressed = rsp_bump_ff;

endmodule
